>>> rtl/hid_input_conditioner_unit_macros.svh
// Assertion macros shared by the input conditioner RTL
`ifndef HID_INPUT_CONDITIONER_UNIT_MACROS_SVH
`define HID_INPUT_CONDITIONER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define HIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hic_pkg.sv
// Shared types, constants and register codes for the input conditioner
`timescale 1ns / 1ps

package hic_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned VALUE_W        = 16;
  localparam int unsigned SPAN_W         = 17;
  localparam int unsigned DZ_W           = 8;
  localparam int unsigned MAG_W          = 15;
  localparam int unsigned DZ_PROD_W      = DZ_W + SPAN_W;
  localparam int unsigned PROD_W         = SAMPLE_W + GAIN_W;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 17;
  localparam int unsigned GAIN_FRAC_BITS = 8;

  // register reset values
  localparam logic                      RST_ANALOG_MODE = 1'b1;
  localparam logic                      RST_IDLE_LEVEL  = 1'b0;
  localparam logic                      RST_INVERT_SIGN = 1'b0;
  localparam logic signed [GAIN_W-1:0]  RST_GAIN        = 16'sd256;
  localparam logic [DZ_W-1:0]           RST_DEADZONE    = 8'd0;
  localparam logic [VALUE_W-1:0]        RST_MIN_CHANGE  = 16'd0;
  localparam logic signed [VALUE_W-1:0] RST_PRESS_THR   = 16'sd16384;
  localparam logic [SPAN_W-1:0]         RST_SPAN        = 17'd65536;
  localparam logic [SPAN_W-1:0]         SPAN_MIN        = 17'd2;
  localparam logic [SPAN_W-1:0]         SPAN_MAX        = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANALOG_MODE = 3'd0,
    REG_IDLE_LEVEL  = 3'd1,
    REG_INVERT_SIGN = 3'd2,
    REG_GAIN        = 3'd3,
    REG_DEADZONE    = 3'd4,
    REG_MIN_CHANGE  = 3'd5,
    REG_PRESS_THR   = 3'd6,
    REG_REPORT_SPAN = 3'd7
  } hic_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] raw_sample;
    logic                       bounce_active;
  } hic_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] reported_value;
    logic                      pressed;
    logic                      released;
    logic                      just_pressed;
    logic                      just_released;
    logic                      just_changed;
  } hic_out_t;

  // decoded configuration as seen by the datapath
  typedef struct packed {
    logic                      analog_mode;
    logic                      idle_level;
    logic                      invert_sign;
    logic signed [GAIN_W-1:0]  gain;
    logic [VALUE_W-1:0]        min_change;
    logic signed [VALUE_W-1:0] press_threshold;
    logic [MAG_W-1:0]          clamp_lim;
    logic [DZ_PROD_W-1:0]      dz_thresh;
  } hic_cfg_t;

endpackage

>>> rtl/hic_cfg_regs.sv
// Configuration register file with span clamp and deadzone threshold product
`timescale 1ns / 1ps

module hic_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hic_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hic_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output hic_pkg::hic_cfg_t                 cfg_o
);
  import hic_pkg::*;

  logic                      analog_mode_q;
  logic                      idle_level_q;
  logic                      invert_sign_q;
  logic signed [GAIN_W-1:0]  gain_q;
  logic [DZ_W-1:0]           deadzone_q;
  logic [VALUE_W-1:0]        min_change_q;
  logic signed [VALUE_W-1:0] press_thr_q;
  logic [SPAN_W-1:0]         span_q;
  logic [DZ_PROD_W-1:0]      dz_thresh_q;
  logic [DZ_PROD_W-1:0]      dz_thresh_d;
  logic [SPAN_W-1:0]         span_eff;
  logic [MAG_W-1:0]          clamp_lim;

  always_comb begin
    if (span_q < SPAN_MIN) begin
      span_eff = SPAN_MIN;
    end else if (span_q > SPAN_MAX) begin
      span_eff = SPAN_MAX;
    end else begin
      span_eff = span_q;
    end
  end

  // span/2 - 1, at most 32767
  assign clamp_lim   = MAG_W'(span_eff[SPAN_W-1:1] - 16'd1);
  assign dz_thresh_d = DZ_PROD_W'(deadzone_q) * DZ_PROD_W'(span_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      analog_mode_q <= RST_ANALOG_MODE;
      idle_level_q  <= RST_IDLE_LEVEL;
      invert_sign_q <= RST_INVERT_SIGN;
      gain_q        <= RST_GAIN;
      deadzone_q    <= RST_DEADZONE;
      min_change_q  <= RST_MIN_CHANGE;
      press_thr_q   <= RST_PRESS_THR;
      span_q        <= RST_SPAN;
      dz_thresh_q   <= '0;
    end else begin
      dz_thresh_q <= dz_thresh_d;
      if (cfg_we_i) begin
        case (hic_reg_e'(cfg_idx_i))
          REG_ANALOG_MODE: analog_mode_q <= cfg_wdata_i[0];
          REG_IDLE_LEVEL:  idle_level_q  <= cfg_wdata_i[0];
          REG_INVERT_SIGN: invert_sign_q <= cfg_wdata_i[0];
          REG_GAIN:        gain_q        <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          REG_DEADZONE:    deadzone_q    <= cfg_wdata_i[DZ_W-1:0];
          REG_MIN_CHANGE:  min_change_q  <= cfg_wdata_i[VALUE_W-1:0];
          REG_PRESS_THR:   press_thr_q   <= $signed(cfg_wdata_i[VALUE_W-1:0]);
          REG_REPORT_SPAN: span_q        <= cfg_wdata_i[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg_o                 = '0;
    cfg_o.analog_mode     = analog_mode_q;
    cfg_o.idle_level      = idle_level_q;
    cfg_o.invert_sign     = invert_sign_q;
    cfg_o.gain            = gain_q;
    cfg_o.min_change      = min_change_q;
    cfg_o.press_threshold = press_thr_q;
    cfg_o.clamp_lim       = clamp_lim;
    cfg_o.dz_thresh       = dz_thresh_q;
  end

endmodule

>>> rtl/hid_input_conditioner_unit.sv
// Input conditioner top: sample register, gain multiply stage, condition/state stage
//
//  channel  | signals                              | beat
//  ---------+--------------------------------------+----------------------------------
//  in       | in_valid_i, in_ready_o, in_data_i    | one raw sample + bounce flag
//  out      | out_valid_o, out_ready_i, out_data_o | conditioned value + press/edge flags
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i     | one register write, no handshake
//
// Three register stages: input, gain product, result. out_valid_o rises once the beat
// has passed the gain product and result registers; throughput one beat per cycle while
// out is not stalled; the value state loop closes inside the result stage.
// Reset clears all valids, the value state and the registers to their defaults.
// A stall on out backs up stage by stage; in stays ready while any stage has room.
// The deadzone threshold is re-registered in the cycle after a config write.
`timescale 1ns / 1ps

module hid_input_conditioner_unit #(
  parameter int unsigned GainFracBits = hic_pkg::GAIN_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hic_pkg::hic_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hic_pkg::hic_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [hic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hic_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import hic_pkg::*;
  `include "hid_input_conditioner_unit_macros.svh"

  localparam logic signed [PROD_W-1:0] FracMask = PROD_W'((64'd1 << GainFracBits) - 64'd1);

  hic_cfg_t cfg;

  hic_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipeline registers
  logic                      in_v_q, p_v_q, out_v_q;
  hic_in_t                   in_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      p_bit0_q, p_bounce_q;
  hic_out_t                  out_q, out_d;
  logic signed [VALUE_W-1:0] cur_q, cur_d, prior_q;

  logic s0_rdy, s1_rdy, s2_rdy;
  logic in_fire, s1_fire, s2_fire;

  assign s2_rdy  = !out_v_q || out_ready_i;
  assign s1_rdy  = !p_v_q || s2_rdy;
  assign s0_rdy  = !in_v_q || s1_rdy;
  assign in_fire = in_valid_i && s0_rdy;
  assign s1_fire = in_v_q && s1_rdy;
  assign s2_fire = p_v_q && s2_rdy;

  assign in_ready_o  = s0_rdy;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // stage 1: gain product
  logic signed [PROD_W-1:0] mul_d;
  assign mul_d = in_q.raw_sample * cfg.gain;

  // stage 2: scale, clamp, deadzone, min step, digital path, flags
  logic                      neg;
  logic signed [PROD_W-1:0]  adj, sc, lim_w, cl;
  logic signed [VALUE_W-1:0] cl16, nv, dv;
  logic [MAG_W-1:0]          mag;
  logic [DZ_PROD_W-1:0]      mag255;
  logic                      in_dz, big_step, active;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W:0]          adiff;
  logic                      pn, pp;

  function automatic logic value_pressed(logic signed [VALUE_W-1:0] v, logic analog,
                                         logic signed [VALUE_W-1:0] thr);
    if (analog) begin
      return v >= thr;
    end
    return v != '0;
  endfunction

  always_comb begin
    // truncate toward zero: bias negative products before the arithmetic shift
    neg   = prod_q[PROD_W-1];
    adj   = prod_q + (neg ? FracMask : '0);
    sc    = adj >>> GainFracBits;
    lim_w = $signed(PROD_W'(cfg.clamp_lim));
    if (sc > lim_w) begin
      cl = lim_w;
    end else if (sc < -lim_w) begin
      cl = -lim_w;
    end else begin
      cl = sc;
    end
    cl16   = VALUE_W'(cl);
    nv     = cfg.invert_sign ? -cl16 : cl16;
    mag    = MAG_W'(nv[VALUE_W-1] ? -nv : nv);
    // |v| * 255 as a shift and subtract
    mag255 = DZ_PROD_W'({mag, 8'd0}) - DZ_PROD_W'(mag);
    in_dz  = mag255 < cfg.dz_thresh;
    diff   = {cur_q[VALUE_W-1], cur_q} - {nv[VALUE_W-1], nv};
    adiff  = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : (VALUE_W+1)'(diff);
    big_step = adiff >= {1'b0, cfg.min_change};

    active = p_bit0_q != cfg.idle_level;
    if (!active) begin
      dv = '0;
    end else if (cfg.invert_sign) begin
      dv = -VALUE_W'(1);
    end else begin
      dv = VALUE_W'(1);
    end

    if (cfg.analog_mode) begin
      if (in_dz) begin
        cur_d = '0;
      end else if (big_step) begin
        cur_d = nv;
      end else begin
        cur_d = cur_q;
      end
    end else if (p_bounce_q) begin
      cur_d = cur_q;
    end else begin
      cur_d = dv;
    end

    pn = value_pressed(cur_d, cfg.analog_mode, cfg.press_threshold);
    pp = value_pressed(cur_q, cfg.analog_mode, cfg.press_threshold);
    out_d.reported_value = cur_d;
    out_d.pressed        = pn;
    out_d.released       = !pn;
    out_d.just_pressed   = pn && !pp;
    out_d.just_released  = !pn && pp;
    out_d.just_changed   = pn != pp;
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      p_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      cur_q   <= '0;
      prior_q <= '0;
    end else begin
      if (s0_rdy) begin
        in_v_q <= in_valid_i;
      end
      if (s1_rdy) begin
        p_v_q <= in_v_q;
      end
      if (s2_rdy) begin
        out_v_q <= p_v_q;
      end
      if (s2_fire) begin
        prior_q <= cur_q;
        cur_q   <= cur_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (s1_fire) begin
      prod_q     <= mul_d;
      p_bit0_q   <= in_q.raw_sample[0];
      p_bounce_q <= in_q.bounce_active;
    end
    if (s2_fire) begin
      out_q <= out_d;
    end
  end

  `HIC_ASSERT_NXT(a_prior_follows, s2_fire, prior_q == $past(cur_q), "prior value not stepped")
  `HIC_ASSERT_NXT(a_bounce_holds, s2_fire && !cfg.analog_mode && p_bounce_q,
                  cur_q == $past(cur_q), "value moved during bounce")
  `HIC_ASSERT_IMP(a_value_range, out_v_q, out_q.reported_value != 16'sh8000,
                  "reported value out of range")
  `HIC_ASSERT_IMP(a_full_when_blocked, !in_ready_o, in_v_q && p_v_q && out_v_q,
                  "input blocked with a free stage")
  `HIC_ASSERT_IMP(a_edge_flags, out_v_q && out_q.just_pressed,
                  out_q.pressed && out_q.just_changed, "press edge without press")

endmodule
